/* sv/dlm_pkg.sv */
// ----------------------------------------------------------------------------
// dlm_pkg: shared types and constants of the dense layer MAC
// Field widths, request and register codes, and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dlm_pkg;

  // Activation store geometry
  localparam int MAX_INPUTS = 256;
  localparam int STORE_AW   = 8;    // bits of an activation index

  // Field widths
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 8;
  localparam int VAL_W   = 16;
  localparam int ROW_W   = 16;
  localparam int RES_W   = 32;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 48;
  localparam int ICNT_W  = 9;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 16;
  localparam int BIAS_SH = 12;      // Q4.12 bias aligned to Q8.24

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_ACT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MAC  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_BIAS = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_INPUT_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_ROW_COUNT   = 2'd1;

  // Reset values of the configuration registers
  localparam logic [ICNT_W-1:0] INPUT_COUNT_RST = 9'd256;
  localparam logic [ROW_W-1:0]  ROW_COUNT_RST   = 16'd1;

  // Controller to datapath
  typedef struct packed {
    logic wr_act;   // write the incoming activation
    logic load;     // read the store and capture the incoming value
    logic mul;      // register the product
    logic acc;      // add the product to the row accumulator
    logic emit;     // close the row into the output register
  } dlm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic idx_ok;   // incoming index lies below the input count
    logic out_free; // output register can take a result this cycle
  } dlm_sts_t;

endpackage

/* sv/dense_layer_mac_top.sv */
// ----------------------------------------------------------------------------
// dense_layer_mac_top: fixed-point dense layer row engine, y = W*x + b
// Usage:
//   Input stream (in_*): one request per beat. in_tuser carries the kind:
//   activation write, weight multiply-accumulate or bias (closes a row).
//   Activation and weight beats whose index is at or beyond input_count are
//   dropped. Each bias beat yields exactly one output beat with the row
//   number, the Q8.24 saturated sum and tlast set on the final row.
//   Config port (cfg_*): index 0 input_count, index 1 row_count; always
//   ready, write only while the block is idle.
// Timing:
//   Activation write on acceptance. Weight: store read, registered multiply,
//   saturating accumulate. Bias: value capture, then close; result visible
//   the cycle after the close. One beat is in work at a time; the three-step
//   weight path through the store read port and multiplier sets the rate.
// Reset (rst_n, synchronous): clears accumulator, row counter and output
//   valid, loads input_count 256 and row_count 1; store contents stay.
// Stall: the output register holds a waiting result while activation and
//   weight beats keep flowing; a following bias beat waits in the close step.
// ----------------------------------------------------------------------------
module dense_layer_mac_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] elem_index, [23:8] value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] row_index, [47:16] result_value
  output logic        out_tlast,  // last_row
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dlm_pkg::dlm_cmd_t                     cmd;
  dlm_pkg::dlm_sts_t                     sts;
  logic [dlm_pkg::ROW_W-1:0]             row_index;
  logic signed [dlm_pkg::RES_W-1:0]      result_value;

  // Config writes never stall
  assign cfg_ready = 1'b1;

  dlm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_req_type (in_tuser),
    .in_ready    (in_tready),
    .sts         (sts),
    .cmd         (cmd)
  );

  dlm_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_elem_index    (in_tdata[7:0]),
    .in_value         (in_tdata[23:8]),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_ready        (out_tready),
    .out_valid        (out_tvalid),
    .out_row_index    (row_index),
    .out_result_value (result_value),
    .out_last_row     (out_tlast)
  );

  // Pack result fields, row number in the low half-word
  assign out_tdata = {result_value, row_index};

endmodule

/* sv/dlm_ctrl.sv */
// ----------------------------------------------------------------------------
// dlm_ctrl: sequencing state machine of the dense layer MAC
// Takes one beat at a time and steps the datapath through read, multiply,
// accumulate or row close.
// ----------------------------------------------------------------------------
module dlm_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [dlm_pkg::REQ_W-1:0]   in_req_type,
  output logic                        in_ready,
  input  dlm_pkg::dlm_sts_t           sts,
  output dlm_pkg::dlm_cmd_t           cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            dlm_pkg::REQ_ACT: begin
              cmd.wr_act = sts.idx_ok;
            end
            dlm_pkg::REQ_MAC: begin
              if (sts.idx_ok) begin
                cmd.load  = 1'b1;
                state_nxt = ST_MUL;
              end
            end
            dlm_pkg::REQ_BIAS: begin
              cmd.load  = 1'b1;
              state_nxt = ST_EMIT;
            end
            default: begin
              // unused request kind: drop
            end
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted in-range weight always goes on to multiply
  a_mac_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == dlm_pkg::REQ_MAC && sts.idx_ok) |=> state_r == ST_MUL)
    else $error("weight beat did not start a multiply");

  // Multiply is always followed by accumulate
  a_mul_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |=> cmd.acc)
    else $error("multiply not followed by accumulate");

  // A row closes only into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("row closed into a busy output register");

endmodule

/* sv/dlm_datapath.sv */
// ----------------------------------------------------------------------------
// dlm_datapath: storage and arithmetic of the dense layer MAC
// Activation store, configuration registers, multiplier, saturating row
// accumulator, row counter and output register.
// ----------------------------------------------------------------------------
module dlm_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dlm_pkg::dlm_cmd_t                   cmd,
  output dlm_pkg::dlm_sts_t                   sts,
  input  logic [dlm_pkg::IDX_W-1:0]           in_elem_index,
  input  logic signed [dlm_pkg::VAL_W-1:0]    in_value,
  input  logic                                cfg_we,
  input  logic [dlm_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [dlm_pkg::CDATA_W-1:0]         cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [dlm_pkg::ROW_W-1:0]           out_row_index,
  output logic signed [dlm_pkg::RES_W-1:0]    out_result_value,
  output logic                                out_last_row
);

  localparam int SUM_W = dlm_pkg::ACC_W + 1;
  localparam logic signed [SUM_W-1:0] ACC_MAX =
    SUM_W'({1'b0, {(dlm_pkg::ACC_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] ACC_MIN =
    {{(SUM_W-dlm_pkg::ACC_W+1){1'b1}}, {(dlm_pkg::ACC_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] RES_MAX =
    SUM_W'({1'b0, {(dlm_pkg::RES_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] RES_MIN =
    {{(SUM_W-dlm_pkg::RES_W+1){1'b1}}, {(dlm_pkg::RES_W-1){1'b0}}};

  logic [dlm_pkg::VAL_W-1:0]               store [dlm_pkg::MAX_INPUTS];
  logic signed [dlm_pkg::VAL_W-1:0]        act_r;
  logic signed [dlm_pkg::VAL_W-1:0]        val_r;
  logic signed [dlm_pkg::PROD_W-1:0]       prod_r;
  logic signed [dlm_pkg::ACC_W-1:0]        acc_r;
  logic signed [dlm_pkg::ACC_W-1:0]        acc_nxt;
  logic [dlm_pkg::ROW_W-1:0]               row_r;
  logic [dlm_pkg::ROW_W-1:0]               row_nxt;
  logic [dlm_pkg::ICNT_W-1:0]              input_count_r;
  logic [dlm_pkg::ROW_W-1:0]               row_count_r;
  logic                                    out_valid_r;
  logic [dlm_pkg::ROW_W-1:0]               out_row_r;
  logic signed [dlm_pkg::RES_W-1:0]        out_res_r;
  logic                                    out_last_r;
  logic signed [SUM_W-1:0]                 mac_sum;
  logic signed [SUM_W-1:0]                 row_sum;
  logic signed [dlm_pkg::RES_W-1:0]        res_sat;
  logic                                    last;
  logic [dlm_pkg::STORE_AW-1:0]            addr;

  assign addr = in_elem_index[dlm_pkg::STORE_AW-1:0];

  // Index in range: below the input count and inside the store
  assign sts.idx_ok   = ({1'b0, in_elem_index} < input_count_r) &&
                        (32'(in_elem_index) < 32'(dlm_pkg::MAX_INPUTS));
  assign sts.out_free = !out_valid_r || out_ready;

  // Accumulate with saturation to the 48-bit range
  always_comb begin
    mac_sum = SUM_W'(acc_r) + SUM_W'(prod_r);
    if (mac_sum > ACC_MAX) begin
      acc_nxt = dlm_pkg::ACC_W'(ACC_MAX);
    end else if (mac_sum < ACC_MIN) begin
      acc_nxt = dlm_pkg::ACC_W'(ACC_MIN);
    end else begin
      acc_nxt = mac_sum[dlm_pkg::ACC_W-1:0];
    end
  end

  // Row close: accumulator plus aligned bias, saturated to 32 bits
  always_comb begin
    row_sum = SUM_W'(acc_r) + (SUM_W'(val_r) <<< dlm_pkg::BIAS_SH);
    if (row_sum > RES_MAX) begin
      res_sat = dlm_pkg::RES_W'(RES_MAX);
    end else if (row_sum < RES_MIN) begin
      res_sat = dlm_pkg::RES_W'(RES_MIN);
    end else begin
      res_sat = row_sum[dlm_pkg::RES_W-1:0];
    end
    last    = ({1'b0, row_r} + 17'd1) >= {1'b0, row_count_r};
    row_nxt = last ? '0 : row_r + 16'd1;
  end

  // Activation store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_act) begin
      store[addr] <= in_value;
    end
    if (cmd.load) begin
      act_r <= store[addr];
      val_r <= in_value;
    end
    if (cmd.mul) begin
      prod_r <= act_r * val_r;
    end
    if (cmd.emit) begin
      out_row_r  <= row_r;
      out_res_r  <= res_sat;
      out_last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r         <= '0;
      row_r         <= '0;
      input_count_r <= dlm_pkg::INPUT_COUNT_RST;
      row_count_r   <= dlm_pkg::ROW_COUNT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.emit) begin
        acc_r <= '0;
        row_r <= row_nxt;
      end else if (cmd.acc) begin
        acc_r <= acc_nxt;
      end
      if (cfg_we && cfg_index == dlm_pkg::CFG_INPUT_COUNT) begin
        input_count_r <= cfg_data[dlm_pkg::ICNT_W-1:0];
      end
      if (cfg_we && cfg_index == dlm_pkg::CFG_ROW_COUNT) begin
        row_count_r <= cfg_data[dlm_pkg::ROW_W-1:0];
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_index    = out_row_r;
  assign out_result_value = out_res_r;
  assign out_last_row     = out_last_r;

  // A closed row clears the accumulator and presents a result
  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (acc_r == '0) && out_valid_r)
    else $error("row close did not clear accumulator or raise valid");

  // The row counter wraps to zero after the close of the last row
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && last) |=> row_r == '0)
    else $error("row counter did not wrap on the last row");

  // A stalled result holds its valid and its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_res_r) &&
                                    $stable(out_row_r) && $stable(out_last_r))
    else $error("stalled result changed");

endmodule
